### rtl/dhcp_rp_pkg.sv
package dhcp_rp_pkg;

  localparam int MaxBytes         = 576;
  localparam int FixedHeaderBytes = 236;
  localparam int OffW             = $clog2(MaxBytes + 1);
  localparam int XidW             = 32;
  localparam int MinLenW          = 10;
  localparam int CfgDataW         = 32;
  localparam int CfgIdxW          = 1;

  typedef logic [OffW-1:0] off_t;

  localparam off_t MaxBytesOff  = off_t'(MaxBytes);
  localparam off_t CookieOff    = off_t'(FixedHeaderBytes);
  localparam off_t OptionsOff   = off_t'(FixedHeaderBytes + 4);

  localparam logic [7:0] OpReply    = 8'd2;
  localparam logic [7:0] HtypeEther = 8'd1;
  localparam logic [7:0] HlenEther  = 8'd6;

  localparam logic [7:0] OptPad    = 8'd0;
  localparam logic [7:0] OptMask   = 8'd1;
  localparam logic [7:0] OptRouter = 8'd3;
  localparam logic [7:0] OptLease  = 8'd51;
  localparam logic [7:0] OptType   = 8'd53;
  localparam logic [7:0] OptServer = 8'd54;
  localparam logic [7:0] OptEnd    = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_XID = 1'b0,
    CFG_MIN_LENGTH   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_HEADER    = 3'd2,
    ST_XID       = 3'd3,
    ST_COOKIE    = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_MISSING   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  message_type;
    logic [31:0] offered_ip;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [31:0] server_id;
    logic [31:0] lease_seconds;
  } result_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'd99;
      2'd1: b = 8'd130;
      2'd2: b = 8'd83;
      default: b = 8'd99;
    endcase
    return b;
  endfunction

endpackage

### rtl/dhcp_rp_if.sv
interface dhcp_rp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source(output valid, output data_byte, output last, input ready);
  modport sink(input valid, input data_byte, input last, output ready);
endinterface

interface dhcp_rp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  message_type;
  logic [31:0] offered_ip;
  logic [31:0] netmask;
  logic [31:0] gateway;
  logic [31:0] server_id;
  logic [31:0] lease_seconds;

  modport source(output valid, output status, output message_type, output offered_ip,
                 output netmask, output gateway, output server_id,
                 output lease_seconds, input ready);
  modport sink(input valid, input status, input message_type, input offered_ip,
               input netmask, input gateway, input server_id,
               input lease_seconds, output ready);
endinterface

### rtl/dhcp_rp_core.sv
module dhcp_rp_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               take,
  input  logic [7:0]                         data_byte,
  input  logic                               last,
  input  logic [dhcp_rp_pkg::XidW-1:0]       expected_xid,
  input  logic [dhcp_rp_pkg::MinLenW-1:0]    min_length,
  output dhcp_rp_pkg::result_t               result
);

  dhcp_rp_pkg::off_t   off_r, off_nxt;
  logic                hdr_bad_r, hdr_bad_nxt;
  logic                xid_bad_r, xid_bad_nxt;
  logic                cookie_bad_r, cookie_bad_nxt;
  logic [31:0]         xid_shift_r, xid_shift_nxt;
  dhcp_rp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]          opt_code_r, opt_code_nxt;
  logic [7:0]          bytes_left_r, bytes_left_nxt;
  logic [31:0]         value_shift_r, value_shift_nxt;
  logic [8:0]          value_count_r, value_count_nxt;
  logic [31:0]         yiaddr_r, yiaddr_nxt;
  logic [31:0]         mask_r, mask_nxt;
  logic [31:0]         router_r, router_nxt;
  logic [31:0]         server_r, server_nxt;
  logic [31:0]         lease_r, lease_nxt;
  logic [7:0]          type_r, type_nxt;

  dhcp_rp_pkg::off_t   need;
  dhcp_rp_pkg::off_t   cookie_idx;
  logic [31:0]         shifted_xid;
  logic [31:0]         shifted_val;
  logic [8:0]          count_inc;
  logic [7:0]          left_dec;
  logic                fields_zero;

  always_comb begin
    off_nxt         = off_r;
    hdr_bad_nxt     = hdr_bad_r;
    xid_bad_nxt     = xid_bad_r;
    cookie_bad_nxt  = cookie_bad_r;
    xid_shift_nxt   = xid_shift_r;
    phase_nxt       = phase_r;
    opt_code_nxt    = opt_code_r;
    bytes_left_nxt  = bytes_left_r;
    value_shift_nxt = value_shift_r;
    value_count_nxt = value_count_r;
    yiaddr_nxt      = yiaddr_r;
    mask_nxt        = mask_r;
    router_nxt      = router_r;
    server_nxt      = server_r;
    lease_nxt       = lease_r;
    type_nxt        = type_r;

    shifted_xid = {xid_shift_r[23:0], data_byte};
    shifted_val = (value_count_r < 9'd4) ? {value_shift_r[23:0], data_byte}
                                         : value_shift_r;
    count_inc   = value_count_r + 9'd1;
    left_dec    = bytes_left_r - 8'd1;
    cookie_idx  = off_r - dhcp_rp_pkg::CookieOff;

    if (off_r < dhcp_rp_pkg::MaxBytesOff) begin
      off_nxt = off_r + dhcp_rp_pkg::off_t'(1);
      priority if (off_r == dhcp_rp_pkg::off_t'(0)) begin
        if (data_byte != dhcp_rp_pkg::OpReply) hdr_bad_nxt = 1'b1;
      end else if (off_r == dhcp_rp_pkg::off_t'(1)) begin
        if (data_byte != dhcp_rp_pkg::HtypeEther) hdr_bad_nxt = 1'b1;
      end else if (off_r == dhcp_rp_pkg::off_t'(2)) begin
        if (data_byte != dhcp_rp_pkg::HlenEther) hdr_bad_nxt = 1'b1;
      end else if (off_r >= dhcp_rp_pkg::off_t'(4) && off_r <= dhcp_rp_pkg::off_t'(7)) begin
        xid_shift_nxt = shifted_xid;
        if (off_r == dhcp_rp_pkg::off_t'(7) && shifted_xid != expected_xid) begin
          xid_bad_nxt = 1'b1;
        end
      end else if (off_r >= dhcp_rp_pkg::off_t'(16) && off_r <= dhcp_rp_pkg::off_t'(19)) begin
        yiaddr_nxt = {yiaddr_r[23:0], data_byte};
      end else if (off_r >= dhcp_rp_pkg::CookieOff && off_r < dhcp_rp_pkg::OptionsOff) begin
        if (data_byte != dhcp_rp_pkg::cookie_byte(cookie_idx[1:0])) cookie_bad_nxt = 1'b1;
      end else if (off_r >= dhcp_rp_pkg::OptionsOff) begin
        unique case (phase_r)
          dhcp_rp_pkg::PH_CODE: begin
            if (data_byte == dhcp_rp_pkg::OptEnd) begin
              phase_nxt = dhcp_rp_pkg::PH_DONE;
            end else if (data_byte != dhcp_rp_pkg::OptPad) begin
              opt_code_nxt = data_byte;
              phase_nxt    = dhcp_rp_pkg::PH_LEN;
            end
          end
          dhcp_rp_pkg::PH_LEN: begin
            bytes_left_nxt  = data_byte;
            value_count_nxt = 9'd0;
            value_shift_nxt = 32'd0;
            // A zero-length option can never satisfy any of the captured options.
            phase_nxt = (data_byte == 8'd0) ? dhcp_rp_pkg::PH_CODE : dhcp_rp_pkg::PH_VALUE;
          end
          dhcp_rp_pkg::PH_VALUE: begin
            value_shift_nxt = shifted_val;
            value_count_nxt = count_inc;
            bytes_left_nxt  = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = dhcp_rp_pkg::PH_CODE;
              priority if (opt_code_r == dhcp_rp_pkg::OptType && count_inc == 9'd1) begin
                type_nxt = shifted_val[7:0];
              end else if (opt_code_r == dhcp_rp_pkg::OptMask && count_inc == 9'd4) begin
                mask_nxt = shifted_val;
              end else if (opt_code_r == dhcp_rp_pkg::OptRouter && count_inc >= 9'd4) begin
                router_nxt = shifted_val;
              end else if (opt_code_r == dhcp_rp_pkg::OptServer && count_inc == 9'd4) begin
                server_nxt = shifted_val;
              end else if (opt_code_r == dhcp_rp_pkg::OptLease && count_inc == 9'd4) begin
                lease_nxt = shifted_val;
              end else begin
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
      end
    end

    // The cookie position sets a floor on the length, whatever min_length holds.
    need = (min_length < dhcp_rp_pkg::OptionsOff) ? dhcp_rp_pkg::OptionsOff : min_length;

    priority if (off_nxt < need)    result.status = dhcp_rp_pkg::ST_SHORT;
    else if (hdr_bad_nxt)           result.status = dhcp_rp_pkg::ST_HEADER;
    else if (xid_bad_nxt)           result.status = dhcp_rp_pkg::ST_XID;
    else if (cookie_bad_nxt)        result.status = dhcp_rp_pkg::ST_COOKIE;
    else if (phase_nxt == dhcp_rp_pkg::PH_LEN || phase_nxt == dhcp_rp_pkg::PH_VALUE)
                                    result.status = dhcp_rp_pkg::ST_TRUNCATED;
    else if (type_nxt == 8'd0 || yiaddr_nxt == 32'd0)
                                    result.status = dhcp_rp_pkg::ST_MISSING;
    else                            result.status = dhcp_rp_pkg::ST_OK;

    fields_zero = (result.status == dhcp_rp_pkg::ST_SHORT)  ||
                  (result.status == dhcp_rp_pkg::ST_HEADER) ||
                  (result.status == dhcp_rp_pkg::ST_XID)    ||
                  (result.status == dhcp_rp_pkg::ST_COOKIE);

    result.message_type  = fields_zero ? 8'd0  : type_nxt;
    result.offered_ip    = fields_zero ? 32'd0 : yiaddr_nxt;
    result.netmask       = fields_zero ? 32'd0 : mask_nxt;
    result.gateway       = fields_zero ? 32'd0 : router_nxt;
    result.server_id     = fields_zero ? 32'd0 : server_nxt;
    result.lease_seconds = fields_zero ? 32'd0 : lease_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      off_r         <= '0;
      hdr_bad_r     <= 1'b0;
      xid_bad_r     <= 1'b0;
      cookie_bad_r  <= 1'b0;
      xid_shift_r   <= '0;
      phase_r       <= dhcp_rp_pkg::PH_CODE;
      opt_code_r    <= '0;
      bytes_left_r  <= '0;
      value_shift_r <= '0;
      value_count_r <= '0;
      yiaddr_r      <= '0;
      mask_r        <= '0;
      router_r      <= '0;
      server_r      <= '0;
      lease_r       <= '0;
      type_r        <= '0;
    end else if (take) begin
      off_r         <= off_nxt;
      hdr_bad_r     <= hdr_bad_nxt;
      xid_bad_r     <= xid_bad_nxt;
      cookie_bad_r  <= cookie_bad_nxt;
      xid_shift_r   <= xid_shift_nxt;
      phase_r       <= phase_nxt;
      opt_code_r    <= opt_code_nxt;
      bytes_left_r  <= bytes_left_nxt;
      value_shift_r <= value_shift_nxt;
      value_count_r <= value_count_nxt;
      yiaddr_r      <= yiaddr_nxt;
      mask_r        <= mask_nxt;
      router_r      <= router_nxt;
      server_r      <= server_nxt;
      lease_r       <= lease_nxt;
      type_r        <= type_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> off_r == '0 && phase_r == dhcp_rp_pkg::PH_CODE)
    else $error("per-reply state not cleared after the final byte");

  a_offset_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= dhcp_rp_pkg::MaxBytesOff)
    else $error("byte offset ran past the maximum reply length");

  a_end_option_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == dhcp_rp_pkg::PH_DONE && !(take && last) |=> phase_r == dhcp_rp_pkg::PH_DONE)
    else $error("option walk resumed after the end option");

endmodule

### rtl/dhcp_reply_parser_unit.sv
// Channel  Direction  Payload
// in_chan  sink       data_byte[7:0], last
// out_chan source     status[2:0], message_type[7:0], offered_ip, netmask, gateway,
//                     server_id, lease_seconds (32 bits each)
// cfg      write      cfg_we, cfg_index (0 expected_xid, 1 min_length), cfg_data[31:0]
//
// One byte is accepted per cycle while no final byte waits on a stalled result;
// a byte waits in the input register and is folded into the reply state when taken.
// The final byte of a reply loads the result register on the edge that folds it in.
// A stalled result holds a final byte in the input register, which stalls the input.
// Synchronous active-low reset clears per-reply state and the valid flags.
module dhcp_reply_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dhcp_rp_in_if.sink                           in_chan,
  dhcp_rp_out_if.source                        out_chan,
  input  logic                                 cfg_we,
  input  logic [dhcp_rp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [dhcp_rp_pkg::CfgDataW-1:0]     cfg_data
);

  logic                                  s1_valid_r;
  logic [7:0]                            s1_byte_r;
  logic                                  s1_last_r;
  logic                                  take;
  logic                                  out_valid_r;
  dhcp_rp_pkg::result_t                  out_r;
  dhcp_rp_pkg::result_t                  result;
  logic [dhcp_rp_pkg::XidW-1:0]          expected_xid_r;
  logic [dhcp_rp_pkg::MinLenW-1:0]       min_length_r;

  // A final byte may only proceed when the result register is free or draining.
  assign take = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_xid_r <= '0;
      min_length_r   <= dhcp_rp_pkg::MinLenW'(240);
    end else if (cfg_we) begin
      unique case (dhcp_rp_pkg::cfg_idx_t'(cfg_index))
        dhcp_rp_pkg::CFG_EXPECTED_XID: expected_xid_r <= cfg_data[dhcp_rp_pkg::XidW-1:0];
        dhcp_rp_pkg::CFG_MIN_LENGTH:   min_length_r   <= cfg_data[dhcp_rp_pkg::MinLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last;
    end
  end

  dhcp_rp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .data_byte    (s1_byte_r),
    .last         (s1_last_r),
    .expected_xid (expected_xid_r),
    .min_length   (min_length_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_r.status;
  assign out_chan.message_type  = out_r.message_type;
  assign out_chan.offered_ip    = out_r.offered_ip;
  assign out_chan.netmask       = out_r.netmask;
  assign out_chan.gateway       = out_r.gateway;
  assign out_chan.server_id     = out_r.server_id;
  assign out_chan.lease_seconds = out_r.lease_seconds;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !(take && s1_last_r))
    else $error("pending result overwritten");

  a_ok_has_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == dhcp_rp_pkg::ST_OK |->
      out_r.message_type != 8'd0 && out_r.offered_ip != 32'd0)
    else $error("ok status without message type or offered address");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == dhcp_rp_pkg::ST_SHORT ||
                    out_r.status == dhcp_rp_pkg::ST_HEADER ||
                    out_r.status == dhcp_rp_pkg::ST_XID ||
                    out_r.status == dhcp_rp_pkg::ST_COOKIE) |->
      out_r.message_type == 8'd0 && out_r.offered_ip == 32'd0 && out_r.netmask == 32'd0 &&
      out_r.gateway == 32'd0 && out_r.server_id == 32'd0 && out_r.lease_seconds == 32'd0)
    else $error("failed reply carries nonzero fields");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !take |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("stalled request lost in the input register");

endmodule
